// ===== rtl/core/wsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants for the wheel step accumulator.
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam int unsigned StepW      = 10;
  localparam int unsigned DivW       = 5;
  localparam int unsigned ClicksW    = 7;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned DeltaW     = 11;
  localparam int unsigned AccW       = 17;
  localparam int unsigned ProdW      = ClicksW + StepW + 1;
  localparam int unsigned ThrW       = 15;
  localparam int unsigned CntW       = 5;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 48;

  localparam logic [StepW-1:0] StepReset = 10'd120;
  localparam logic [DivW-1:0]  DivReset  = 5'd1;

  localparam logic signed [ClicksW-1:0] ClicksMax = 7'sd32;
  localparam logic signed [ClicksW-1:0] ClicksMin = -7'sd32;

  localparam logic signed [AccW:0] AccMax = 18'sd65535;
  localparam logic signed [AccW:0] AccMin = -18'sd65536;

  localparam logic [CntW-1:0] CntLast = 5'd31;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepSize     = 1'b0,
    CfgScrollDiv    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMulUnits,
    StMulThr,
    StAcc,
    StCheck,
    StEmit
  } state_e;

endpackage

// ===== rtl/core/wheel_step_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// wheel_step_accumulator_unit
// Scales signed wheel clicks by the step size, accumulates them and emits
// fixed-size wheel events tagged with the pointer position.
// ----------------------------------------------------------------------------
// An item passes StMulUnits and StMulThr (one shared 7x11 multiplier), StAcc and
// StCheck; its events are built in StEmit and registered out. Throughput: one
// event per cycle while the output is not stalled; the input is held until an
// item's last event is emitted. Items with zero clicks or a zero step size are absorbed while idle.
// Reset: accumulator clears, step_size returns to 120, scroll_divisor to 1.
// ----------------------------------------------------------------------------
module wheel_step_accumulator_unit
  import wsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [6:0] wheel_clicks, [22:7] pointer_x, [38:23] pointer_y
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [10:0] wheel_delta, [26:11] event_x, [42:27] event_y
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // last_event
  output logic                m_axis_tlast_o
);

  state_e state_q, state_d;

  logic [StepW-1:0]          step_q, step_d;
  logic [DivW-1:0]           div_q, div_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [ClicksW-1:0] clicks_q, clicks_d;
  logic [CoordW-1:0]         px_q, px_d, py_q, py_d;
  logic signed [AccW-1:0]    units_q, units_d;
  logic [ThrW-1:0]           thr_q, thr_d;
  logic                      neg_q, neg_d;
  logic [CntW-1:0]           cnt_q, cnt_d;

  logic                      ovalid_q, ovalid_d;
  logic signed [DeltaW-1:0]  odelta_q, odelta_d;
  logic [CoordW-1:0]         ox_q, ox_d, oy_q, oy_d;
  logic                      olast_q, olast_d;

  logic signed [ClicksW-1:0] in_clicks, sat_clicks;
  logic [DivW-1:0]           div_eff;
  logic signed [ClicksW-1:0] mul_a;
  logic signed [StepW:0]     mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [AccW:0]      acc_base, acc_sum, acc_x, thr_x, thr2_x;
  logic                      take, slot_free, fire, last_ev;

  assign in_clicks  = s_axis_tdata_i[ClicksW-1:0];
  assign sat_clicks = (in_clicks > ClicksMax) ? ClicksMax :
                      (in_clicks < ClicksMin) ? ClicksMin : in_clicks;
  assign div_eff    = (div_q == '0) ? DivW'(1) : div_q;

  assign mul_a = (state_q == StMulUnits) ? clicks_q : $signed({2'b00, div_eff});
  assign mul_b = $signed({1'b0, step_q});
  assign prod  = mul_a * mul_b;

  assign acc_x    = {acc_q[AccW-1], acc_q};
  assign thr_x    = $signed({{(AccW+1-ThrW){1'b0}}, thr_q});
  assign thr2_x   = $signed({{(AccW-ThrW){1'b0}}, thr_q, 1'b0});
  assign acc_base = (((acc_q > 0) && units_q[AccW-1]) ||
                     ((acc_q < 0) && (units_q > 0))) ? '0 : acc_x;
  assign acc_sum  = acc_base + {units_q[AccW-1], units_q};

  assign take      = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !ovalid_q || m_axis_tready_i;
  assign fire      = (state_q == StEmit) && slot_free;
  assign last_ev   = (cnt_q == CntLast) ||
                     (neg_q ? (acc_x > -thr2_x) : (acc_x < thr2_x));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (take && (sat_clicks != '0) && (step_q != '0)) state_d = StMulUnits;
      end
      StMulUnits: state_d = StMulThr;
      StMulThr:   state_d = StAcc;
      StAcc:      state_d = StCheck;
      StCheck: begin
        if ((acc_x >= thr_x) || (acc_x <= -thr_x)) state_d = StEmit;
        else state_d = StIdle;
      end
      StEmit: begin
        if (fire && last_ev) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == StIdle);
    step_d   = step_q;
    div_d    = div_q;
    acc_d    = acc_q;
    clicks_d = clicks_q;
    px_d     = px_q;
    py_d     = py_q;
    units_d  = units_q;
    thr_d    = thr_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    odelta_d = odelta_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    olast_d  = olast_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgStepSize:  step_d = cfg_data_i[StepW-1:0];
        CfgScrollDiv: div_d  = cfg_data_i[DivW-1:0];
        default:      step_d = step_q;
      endcase
    end
    unique case (state_q)
      StIdle: begin
        if (take) begin
          clicks_d = sat_clicks;
          px_d     = s_axis_tdata_i[ClicksW +: CoordW];
          py_d     = s_axis_tdata_i[ClicksW+CoordW +: CoordW];
        end
      end
      StMulUnits: units_d = prod[AccW-1:0];
      StMulThr:   thr_d   = prod[ThrW-1:0];
      StAcc: begin
        if (acc_sum > AccMax)      acc_d = AccMax[AccW-1:0];
        else if (acc_sum < AccMin) acc_d = AccMin[AccW-1:0];
        else                       acc_d = acc_sum[AccW-1:0];
      end
      StCheck: begin
        neg_d = (acc_x < thr_x);
        cnt_d = '0;
      end
      StEmit: begin
        if (fire) begin
          acc_d    = neg_q ? (acc_q + AccW'(thr_q)) : (acc_q - AccW'(thr_q));
          cnt_d    = cnt_q + CntW'(1);
          ovalid_d = 1'b1;
          odelta_d = neg_q ? -$signed({1'b0, step_q}) : $signed({1'b0, step_q});
          ox_d     = px_q;
          oy_d     = py_q;
          olast_d  = last_ev;
        end
      end
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      step_q   <= StepReset;
      div_q    <= DivReset;
      acc_q    <= '0;
      ovalid_q <= 1'b0;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      div_q    <= div_d;
      acc_q    <= acc_d;
      ovalid_q <= ovalid_d;
      neg_q    <= neg_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clicks_q <= clicks_d;
    px_q     <= px_d;
    py_q     <= py_d;
    units_q  <= units_d;
    thr_q    <= thr_d;
    odelta_q <= odelta_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{(OutDataW-DeltaW-2*CoordW){1'b0}}, oy_q, ox_q, odelta_q};
  assign m_axis_tlast_o  = olast_q;

endmodule

// ===== rtl/core/wsa_checker.sv =====
// ----------------------------------------------------------------------------
// wsa_checker
// Port-level checks for the wheel step accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module wsa_checker
  import wsa_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  a_delta_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[DeltaW-1:0] != '0))
    else $error("wheel event with zero delta");

  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready while an event run is unfinished");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OutDataW-1:DeltaW+2*CoordW] == '0))
    else $error("output padding bits not zero");

endmodule

bind wheel_step_accumulator_unit wsa_checker u_wsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
